>>> design/drs_pkg.sv
// Shared types, field widths, register indexes and reset values for the setpoint ramp scaler.
package drs_pkg;

	// Field widths of the command and result beats.
	localparam int SPEED_W = 16;
	localparam int ANGLE_W = 16;
	localparam int ERPM_W  = 18;
	localparam int SERVO_W = 16;
	localparam int CLIP_W  = 2;
	localparam int LIMIT_W = 17;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 18;

	// Default slew steps in Q7.8 per tick.
	localparam int ACCEL_STEP_DEF = 51;
	localparam int DECEL_STEP_DEF = 77;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_GAIN   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_OFFSET = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEER_GAIN   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STEER_OFFSET = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ERPM_LIMIT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_LOW    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_HIGH   = 3'd6;

	// Register reset values.
	localparam logic [15:0]        SPEED_GAIN_RST   = 16'd4614;
	localparam logic signed [17:0] SPEED_OFFSET_RST = 18'sd0;
	localparam logic signed [15:0] STEER_GAIN_RST   = -16'sd3686;
	localparam logic [15:0]        STEER_OFFSET_RST = 16'd32768;
	localparam logic [16:0]        ERPM_LIMIT_RST   = 17'd20000;
	localparam logic [15:0]        SERVO_LOW_RST    = 16'd9830;
	localparam logic [15:0]        SERVO_HIGH_RST   = 16'd55705;

	// Clip flag codes.
	localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
	localparam logic [CLIP_W-1:0] CLIP_MIN  = 2'd1;
	localparam logic [CLIP_W-1:0] CLIP_MAX  = 2'd2;

	// Scaled and clipped ERPM command with its flag.
	typedef struct packed {
		logic signed [ERPM_W-1:0] cmd;
		logic [CLIP_W-1:0]        clip;
	} erpm_res_t;

	// Scaled and clipped servo position with its flag.
	typedef struct packed {
		logic [SERVO_W-1:0] cmd;
		logic [CLIP_W-1:0]  clip;
	} servo_res_t;

endpackage

>>> design/drs_slew.sv
// Slew limiter: clamps the target speed into a window around the last smoothed speed.
module drs_slew import drs_pkg::*; #(
	parameter int ACCEL_STEP = ACCEL_STEP_DEF,
	parameter int DECEL_STEP = DECEL_STEP_DEF
) (
	input  logic signed [SPEED_W-1:0] last,
	input  logic signed [SPEED_W-1:0] target,
	output logic signed [SPEED_W-1:0] smooth
);

	localparam int EXT_W = SPEED_W + 2;
	localparam logic signed [EXT_W-1:0] ACC = signed'(EXT_W'(ACCEL_STEP));
	localparam logic signed [EXT_W-1:0] DEC = signed'(EXT_W'(DECEL_STEP));
	localparam logic signed [EXT_W-1:0] SAT_HI = signed'(EXT_W'(32767));
	localparam logic signed [EXT_W-1:0] SAT_LO = -signed'(EXT_W'(32768));

	logic signed [EXT_W-1:0] last_x;
	logic signed [EXT_W-1:0] target_x;
	logic signed [EXT_W-1:0] rise;
	logic signed [EXT_W-1:0] fall;
	logic signed [EXT_W-1:0] win_lo;
	logic signed [EXT_W-1:0] win_hi;
	logic signed [EXT_W-1:0] clamped;

	// Steps swap with the sign of the last speed.
	always_comb begin
		last_x   = $signed({{2{last[SPEED_W-1]}}, last});
		target_x = $signed({{2{target[SPEED_W-1]}}, target});
		rise     = (last_x > 0) ? ACC : DEC;
		fall     = (last_x > 0) ? DEC : ACC;
		win_lo   = last_x - fall;
		win_hi   = last_x + rise;
		clamped  = target_x;
		if (clamped < win_lo) begin
			clamped = win_lo;
		end
		if (clamped > win_hi) begin
			clamped = win_hi;
		end
		if (clamped < SAT_LO) begin
			clamped = SAT_LO;
		end
		if (clamped > SAT_HI) begin
			clamped = SAT_HI;
		end
		smooth = clamped[SPEED_W-1:0];
	end

endmodule

>>> design/drs_erpm.sv
// ERPM stage: shifts the registered speed product, adds the offset and clips to the limit.
module drs_erpm import drs_pkg::*; (
	input  logic signed [SPEED_W+16:0] prod,
	input  logic signed [ERPM_W-1:0]   offset,
	input  logic [LIMIT_W-1:0]         limit,
	output erpm_res_t                  res
);

	localparam int SH_W  = SPEED_W + 9;
	localparam int SUM_W = SH_W + 2;

	logic signed [SH_W-1:0]  shifted;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lim_pos;
	logic signed [SUM_W-1:0] lim_neg;

	// Floor shift by 8 is a plain bit select of the product.
	always_comb begin
		shifted = prod[SPEED_W+16:8];
		sum     = $signed({{2{shifted[SH_W-1]}}, shifted})
			+ $signed({{(SUM_W-ERPM_W){offset[ERPM_W-1]}}, offset});
		lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, limit});
		lim_neg = -lim_pos;
		if (sum < lim_neg) begin
			res.cmd  = lim_neg[ERPM_W-1:0];
			res.clip = CLIP_MIN;
		end else if (sum > lim_pos) begin
			res.cmd  = lim_pos[ERPM_W-1:0];
			res.clip = CLIP_MAX;
		end else begin
			res.cmd  = sum[ERPM_W-1:0];
			res.clip = CLIP_NONE;
		end
	end

endmodule

>>> design/drs_servo.sv
// Servo stage: shifts the registered steering product, adds the offset and clips to the range.
module drs_servo import drs_pkg::*; (
	input  logic signed [2*ANGLE_W-1:0] prod,
	input  logic [SERVO_W-1:0]          offset,
	input  logic [SERVO_W-1:0]          low,
	input  logic [SERVO_W-1:0]          high,
	output servo_res_t                  res
);

	localparam int SH_W  = 2*ANGLE_W - 9;
	localparam int SUM_W = SH_W + 2;

	logic signed [SH_W-1:0]  shifted;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] low_x;
	logic signed [SUM_W-1:0] high_x;

	// The low bound is tested first, so with crossed limits only a sum below the low bound resolves to it.
	always_comb begin
		shifted = prod[2*ANGLE_W-1:9];
		sum     = $signed({{2{shifted[SH_W-1]}}, shifted})
			+ $signed({{(SUM_W-SERVO_W){1'b0}}, offset});
		low_x   = $signed({{(SUM_W-SERVO_W){1'b0}}, low});
		high_x  = $signed({{(SUM_W-SERVO_W){1'b0}}, high});
		if (sum < low_x) begin
			res.cmd  = low;
			res.clip = CLIP_MIN;
		end else if (sum > high_x) begin
			res.cmd  = high;
			res.clip = CLIP_MAX;
		end else begin
			res.cmd  = sum[SERVO_W-1:0];
			res.clip = CLIP_NONE;
		end
	end

endmodule

>>> design/drive_setpoint_ramp_scaler.sv
// Top level of the drive setpoint ramp scaler: config registers, pipeline and stream ports.
//
// Each command beat on the slave stream carries a target speed and a steering angle.
// The speed is slew limited against the last smoothed speed, then scaled to an ERPM
// command and clipped to plus or minus erpm_limit. The angle is scaled to a servo
// position and clipped to [servo_low, servo_high]. One result beat leaves on the
// master stream for every command beat, in order.
// The pipeline has four register ranks: input, slew/steer product, speed product and
// output. One command is taken every cycle while m_tready does not stall the output;
// the slew feedback register last_q sets that rate.
// Each rank has its own valid bit and fills bubbles, so a command is still taken
// while a finished result waits at the output, until all ranks hold data.
// A stall at m_tready holds the output beat stable and backs up stage by stage.
// Reset clears all valid bits, the last smoothed speed to zero and the registers to
// their defaults. Config is written via cfg_we, cfg_index and cfg_data; the user must
// write it only while the pipeline is empty (not enforced); unknown indexes are ignored.
module drive_setpoint_ramp_scaler import drs_pkg::*; #(
	parameter int ACCEL_STEP = ACCEL_STEP_DEF,
	parameter int DECEL_STEP = DECEL_STEP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [31:0]            s_tdata,  // target_speed[15:0], steer_angle[31:16]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [55:0]            m_tdata,  // slewed_speed[15:0], erpm_cmd[33:16],
	                                         // servo_cmd[49:34], zero[55:50]
	output logic [3:0]             m_tuser   // erpm_clip[1:0], servo_clip[3:2]
);

	// Configuration registers.
	logic [15:0]        speed_gain_q;
	logic signed [17:0] speed_offset_q;
	logic signed [15:0] steer_gain_q;
	logic [15:0]        steer_offset_q;
	logic [16:0]        erpm_limit_q;
	logic [15:0]        servo_low_q;
	logic [15:0]        servo_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q   <= SPEED_GAIN_RST;
			speed_offset_q <= SPEED_OFFSET_RST;
			steer_gain_q   <= STEER_GAIN_RST;
			steer_offset_q <= STEER_OFFSET_RST;
			erpm_limit_q   <= ERPM_LIMIT_RST;
			servo_low_q    <= SERVO_LOW_RST;
			servo_high_q   <= SERVO_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_GAIN:   speed_gain_q   <= cfg_data[15:0];
				REG_SPEED_OFFSET: speed_offset_q <= $signed(cfg_data[17:0]);
				REG_STEER_GAIN:   steer_gain_q   <= $signed(cfg_data[15:0]);
				REG_STEER_OFFSET: steer_offset_q <= cfg_data[15:0];
				REG_ERPM_LIMIT:   erpm_limit_q   <= cfg_data[16:0];
				REG_SERVO_LOW:    servo_low_q    <= cfg_data[15:0];
				REG_SERVO_HIGH:   servo_high_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline valid bits and per-stage ready.
	logic v_s1, v_s2, v_s3, v_out_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	assign rdy_out  = !v_out_q || m_tready;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1    <= s_tvalid;
			if (rdy_s2)  v_s2    <= v_s1;
			if (rdy_s3)  v_s3    <= v_s2;
			if (rdy_out) v_out_q <= v_s3;
		end
	end

	// Stage 1: registered command beat.
	logic signed [SPEED_W-1:0] target_s1;
	logic signed [ANGLE_W-1:0] angle_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			target_s1 <= $signed(s_tdata[15:0]);
			angle_s1  <= $signed(s_tdata[31:16]);
		end
	end

	// Slew feedback: the last smoothed speed moves as a beat enters stage 2.
	logic signed [SPEED_W-1:0] last_q;
	logic signed [SPEED_W-1:0] smooth;

	drs_slew #(
		.ACCEL_STEP(ACCEL_STEP),
		.DECEL_STEP(DECEL_STEP)
	) u_slew (
		.last  (last_q),
		.target(target_s1),
		.smooth(smooth)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (v_s1 && rdy_s2) begin
			last_q <= smooth;
		end
	end

	// Stage 2: smoothed speed and steering product.
	logic signed [SPEED_W-1:0]   smooth_s2;
	logic signed [2*ANGLE_W-1:0] steer_prod_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			smooth_s2     <= smooth;
			steer_prod_s2 <= steer_gain_q * angle_s1;
		end
	end

	// Servo scaling and clip on the registered product.
	servo_res_t servo_res;

	drs_servo u_servo (
		.prod  (steer_prod_s2),
		.offset(steer_offset_q),
		.low   (servo_low_q),
		.high  (servo_high_q),
		.res   (servo_res)
	);

	// Stage 3: speed product and finished servo result.
	logic signed [SPEED_W-1:0]  smooth_s3;
	logic signed [SPEED_W+16:0] speed_prod_s3;
	servo_res_t                 servo_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			smooth_s3     <= smooth_s2;
			speed_prod_s3 <= $signed({1'b0, speed_gain_q}) * smooth_s2;
			servo_s3      <= servo_res;
		end
	end

	// ERPM offset and clip on the registered product.
	erpm_res_t erpm_res;

	drs_erpm u_erpm (
		.prod  (speed_prod_s3),
		.offset(speed_offset_q),
		.limit (erpm_limit_q),
		.res   (erpm_res)
	);

	// Output register holds the result beat until it is taken.
	logic signed [SPEED_W-1:0] smooth_out_q;
	erpm_res_t                 erpm_out_q;
	servo_res_t                servo_out_q;

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_out) begin
			smooth_out_q <= smooth_s3;
			erpm_out_q   <= erpm_res;
			servo_out_q  <= servo_s3;
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = {6'b0, servo_out_q.cmd, erpm_out_q.cmd, smooth_out_q};
	assign m_tuser  = {servo_out_q.clip, erpm_out_q.clip};

endmodule

>>> tb/tb_top.sv
// Self-checking stream testbench for the drive setpoint ramp scaler.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import drs_pkg::*;

	// Index 7 is not decoded; writes to it must leave all registers unchanged.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	// One expected result beat.
	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		erpm_res_t                 erpm;
		servo_res_t                servo;
	} drive_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;   // target_speed[15:0], steer_angle[31:16]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [55:0]            m_tdata;        // slewed_speed[15:0], erpm_cmd[33:16],
	                                        // servo_cmd[49:34], zero[55:50]
	logic [3:0]             m_tuser;        // erpm_clip[1:0], servo_clip[3:2]

	// Predictor copy of the registers and the slew state.
	logic [15:0]               reg_speed_gain   = SPEED_GAIN_RST;
	logic signed [17:0]        reg_speed_offset = SPEED_OFFSET_RST;
	logic signed [15:0]        reg_steer_gain   = STEER_GAIN_RST;
	logic [15:0]               reg_steer_offset = STEER_OFFSET_RST;
	logic [16:0]               reg_erpm_limit   = ERPM_LIMIT_RST;
	logic [15:0]               reg_servo_low    = SERVO_LOW_RST;
	logic [15:0]               reg_servo_high   = SERVO_HIGH_RST;
	logic signed [SPEED_W-1:0] ramp_speed       = '0;

	drive_result_t expected_drive_q[$];
	int            mismatch_cnt = 0;
	int            stall_left = 0;
	bit            tx_idle_en = 1'b1;
	bit            rx_idle_en = 1'b1;

	drive_setpoint_ramp_scaler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Slew limit, ERPM scaling and servo scaling for one command tick.
	function automatic drive_result_t predict_drive(input logic signed [SPEED_W-1:0] target,
			input logic signed [ANGLE_W-1:0] angle);
		drive_result_t r;
		int            rise, fall, spd;
		longint        erpm, lim, servo;
		rise = (ramp_speed > 0) ? ACCEL_STEP_DEF : DECEL_STEP_DEF;
		fall = (ramp_speed > 0) ? DECEL_STEP_DEF : ACCEL_STEP_DEF;
		spd = target;
		if (spd < ramp_speed - fall) spd = ramp_speed - fall;
		if (spd > ramp_speed + rise) spd = ramp_speed + rise;
		// The window may run past the 16-bit range near the rails.
		if (spd < -32768) spd = -32768;
		if (spd > 32767) spd = 32767;
		r.speed = spd[SPEED_W-1:0];

		erpm = ((longint'(reg_speed_gain) * spd) >>> 8) + longint'(reg_speed_offset);
		lim = longint'(reg_erpm_limit);
		r.erpm.clip = CLIP_NONE;
		if (erpm < -lim) begin
			erpm = -lim;
			r.erpm.clip = CLIP_MIN;
		end else if (erpm > lim) begin
			erpm = lim;
			r.erpm.clip = CLIP_MAX;
		end
		r.erpm.cmd = erpm[ERPM_W-1:0];

		// Minimum is tested first, which decides the outcome when the limits cross.
		servo = ((longint'(reg_steer_gain) * longint'(angle)) >>> 9)
			+ longint'(reg_steer_offset);
		r.servo.clip = CLIP_NONE;
		if (servo < longint'(reg_servo_low)) begin
			servo = longint'(reg_servo_low);
			r.servo.clip = CLIP_MIN;
		end else if (servo > longint'(reg_servo_high)) begin
			servo = longint'(reg_servo_high);
			r.servo.clip = CLIP_MAX;
		end
		r.servo.cmd = servo[SERVO_W-1:0];
		return r;
	endfunction

	// Write one register at a clock edge and mirror it in the predictor.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_SPEED_GAIN:   reg_speed_gain   = val[15:0];
			REG_SPEED_OFFSET: reg_speed_offset = val;
			REG_STEER_GAIN:   reg_steer_gain   = val[15:0];
			REG_STEER_OFFSET: reg_steer_offset = val[15:0];
			REG_ERPM_LIMIT:   reg_erpm_limit   = val[16:0];
			REG_SERVO_LOW:    reg_servo_low    = val[15:0];
			REG_SERVO_HIGH:   reg_servo_high   = val[15:0];
			default: ;
		endcase
	endtask

	// Load a full register set; unused upper data bits carry junk.
	task automatic load_settings(input logic [15:0] gain, input logic signed [17:0] offset,
			input logic signed [15:0] sgain, input logic [15:0] soff,
			input logic [16:0] lim, input logic [15:0] lo, input logic [15:0] hi);
		write_reg(REG_SPEED_GAIN, {2'($urandom), gain});
		write_reg(REG_SPEED_OFFSET, offset);
		write_reg(REG_STEER_GAIN, {2'($urandom), sgain});
		write_reg(REG_STEER_OFFSET, {2'($urandom), soff});
		write_reg(REG_ERPM_LIMIT, {1'($urandom), lim});
		write_reg(REG_SERVO_LOW, {2'($urandom), lo});
		write_reg(REG_SERVO_HIGH, {2'($urandom), hi});
		write_reg(REG_UNUSED, 18'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Mostly realistic settings, sometimes full-width values and crossed servo limits.
	task automatic load_random_settings();
		logic signed [17:0] offset;
		logic [16:0]        lim;
		logic [15:0]        a, b;
		offset = ($urandom_range(0, 7) == 0) ? 18'($urandom)
			: 18'(int'($urandom_range(0, 200000)) - 100000);
		lim = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 100000));
		a = 16'($urandom);
		b = 16'($urandom);
		if ($urandom_range(0, 3) != 0 && a > b) begin
			a = a ^ b;
			b = a ^ b;
			a = a ^ b;
		end
		load_settings(16'($urandom), offset, 16'($urandom), 16'($urandom), lim, a, b);
	endtask

	// Send one command beat, with an optional idle burst first.
	task automatic send_drive(input logic signed [SPEED_W-1:0] target,
			input logic signed [ANGLE_W-1:0] angle);
		drive_result_t want;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {angle, target};
		do @(posedge clk); while (s_tready !== 1'b1);
		want = predict_drive(target, angle);
		ramp_speed = want.speed;
		expected_drive_q.push_back(want);
	endtask

	// Targets near the last speed may pass or hit the slew window; the rest are random or at the rails.
	task automatic send_random_drive();
		logic signed [SPEED_W-1:0] target;
		logic signed [ANGLE_W-1:0] angle;
		int                        pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			target = 16'(int'(ramp_speed) + int'($urandom_range(0, 240)) - 120);
		else if (pick < 8)
			target = 16'($urandom);
		else
			target = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		if ($urandom_range(0, 7) == 0)
			angle = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		else
			angle = 16'($urandom);
		send_drive(target, angle);
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_drive_q.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Reset register values: both slew directions, sign changes and angle rounding.
	task automatic test_reset_defaults();
		send_drive(16'sd0, 16'sd0);
		send_drive(16'sh7FFF, 16'sh7FFF);
		send_drive(16'sh7FFF, 16'sh8000);
		send_drive(16'sh8000, 16'sd0);
		send_drive(16'sh8000, 16'sd1);
		send_drive(16'sh8000, -16'sd1);
		send_drive(16'sd100, 16'sd8192);
		send_drive(-16'sd40, -16'sd8192);
		send_drive(-16'sd40, 16'sd3);
		send_drive(16'sd20, -16'sd3);
	endtask

	// Register extremes: zero ERPM limit, crossed servo limits, limits hit exactly.
	task automatic test_extreme_settings();
		wait_idle();
		load_settings(16'hFFFF, 18'sd100000, 16'sh8000, 16'hFFFF, 17'd0, 16'hFFFF, 16'd0);
		send_drive(16'sh7FFF, 16'sh8000);
		send_drive(16'sh8000, 16'sh7FFF);
		send_drive(16'sd0, 16'sd0);
		send_drive(16'sd0, 16'sd1);
		wait_idle();
		// Most negative offset, then the largest offset sitting exactly on the limit.
		load_settings(16'd0, 18'sh20000, 16'sh7FFF, 16'd0, 17'h1FFFF, 16'd0, 16'hFFFF);
		send_drive(16'sh8000, 16'sh8000);
		send_drive(16'sh7FFF, 16'sh7FFF);
		wait_idle();
		load_settings(16'd0, 18'sh1FFFF, 16'sd0, 16'hFFFF, 17'h1FFFF, 16'd0, 16'hFFFF);
		send_drive(16'sh7FFF, 16'sd0);
		send_drive(16'sh8000, 16'sh7FFF);
	endtask

	// Ramp the speed up to the upper rail so the slew window runs past 16 bits.
	task automatic test_rail_ramp();
		wait_idle();
		load_random_settings();
		repeat (680)
			send_drive(16'(32767 - int'($urandom_range(0, 40))), 16'($urandom));
	endtask

	task automatic test_random_mix();
		repeat (2) begin
			wait_idle();
			load_random_settings();
			repeat (70) send_random_drive();
		end
	endtask

	// Back-to-back beats on both sides.
	task automatic test_no_idle();
		wait_idle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		load_random_settings();
		repeat (70) send_random_drive();
	endtask

	// Result check against the oldest expectation, and receiver stall bursts.
	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (expected_drive_q.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual tdata %h tuser %h",
					$time, m_tdata, m_tuser);
				mismatch_cnt++;
			end else begin
				want = expected_drive_q.pop_front();
				check_field("slewed_speed", 32'(want.speed), 32'($signed(m_tdata[15:0])));
				check_field("erpm_cmd", 32'($signed(want.erpm.cmd)),
					32'($signed(m_tdata[33:16])));
				check_field("servo_cmd", 32'(want.servo.cmd), 32'(m_tdata[49:34]));
				check_field("tdata padding", 32'd0, 32'(m_tdata[55:50]));
				check_field("erpm_clip", 32'(want.erpm.clip), 32'(m_tuser[1:0]));
				check_field("servo_clip", 32'(want.servo.clip), 32'(m_tuser[3:2]));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extreme_settings();
		test_rail_ramp();
		test_random_mix();
		test_no_idle();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
